// ----- src/fkvc_pkg.sv -----
// Package for the FIFO key-value cache: sizes, request codes and the
// controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps

package fkvc_pkg;

    // Ring of slots; depth must be a power of two (ring wraps by truncation)
    localparam int DEPTH   = 16;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int REQ_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture an accepted item
        logic match;   // compare key against all live entries
        logic commit;  // update state and present the result
    } cmd_t;

endpackage

// ----- src/fkvc_ctrl.sv -----
// Sequencing controller for the FIFO key-value cache.
// Depends on fkvc_pkg (cmd_t).
`timescale 1ns / 1ps

module fkvc_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output fkvc_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_MATCH;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_MATCH:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = busy_reg;
    assign cmd.load   = start & ~busy_reg;
    assign cmd.match  = (state_reg == ST_MATCH);
    assign cmd.commit = (state_reg == ST_COMMIT);

endmodule

// ----- src/fkvc_datapath.sv -----
// Datapath of the FIFO key-value cache: entry storage, parallel key compare,
// ring pointers, capacity register and result registers.
// Depends on fkvc_pkg.
`timescale 1ns / 1ps

module fkvc_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  fkvc_pkg::cmd_t                  cmd,
    input  logic                            cfg_we,
    input  logic [fkvc_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic [fkvc_pkg::REQ_W-1:0]      req_type,
    input  logic [fkvc_pkg::KEY_W-1:0]      key,
    input  logic [fkvc_pkg::VAL_W-1:0]      value_in,
    output logic                            done,
    output logic                            hit,
    output logic [fkvc_pkg::VAL_W-1:0]      value_out,
    output logic                            evicted,
    output logic [fkvc_pkg::KEY_W-1:0]      evicted_key,
    output logic [fkvc_pkg::CNT_W-1:0]      entry_count
);

    // Entry storage (no reset: only live slots are ever read)
    logic [fkvc_pkg::KEY_W-1:0]  key_store [fkvc_pkg::DEPTH];
    logic [fkvc_pkg::VAL_W-1:0]  value_store [fkvc_pkg::DEPTH];

    // Control state
    logic [fkvc_pkg::CAP_W-1:0]  capacity_reg;
    logic [fkvc_pkg::SLOT_W-1:0] oldest_reg, oldest_next;
    logic [fkvc_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic                        done_reg;

    // Captured item
    logic [fkvc_pkg::REQ_W-1:0]  req_reg;
    logic [fkvc_pkg::KEY_W-1:0]  key_reg;
    logic [fkvc_pkg::VAL_W-1:0]  val_reg;

    // Match stage results
    logic                        match_hit_reg;
    logic [fkvc_pkg::SLOT_W-1:0] match_slot_reg;
    logic                        need_evict_reg;

    // Result registers
    logic                        hit_reg, hit_next;
    logic [fkvc_pkg::VAL_W-1:0]  vout_reg, vout_next;
    logic                        ev_reg, ev_next;
    logic [fkvc_pkg::KEY_W-1:0]  evkey_reg, evkey_next;

    // Match stage logic
    logic [fkvc_pkg::DEPTH-1:0]  match_vec;
    logic                        any_match;
    logic [fkvc_pkg::SLOT_W-1:0] first_slot;
    logic [fkvc_pkg::CNT_W-1:0]  eff_cap;

    // Commit stage logic
    logic                        wr_key, wr_val;
    logic [fkvc_pkg::SLOT_W-1:0] wr_slot;
    logic [fkvc_pkg::SLOT_W-1:0] append_slot;

    // Effective capacity: zero acts as one, above depth saturates
    always_comb
    begin
        if (capacity_reg == '0)
            eff_cap = fkvc_pkg::CNT_W'(1);
        else if (int'(capacity_reg) > fkvc_pkg::DEPTH)
            eff_cap = fkvc_pkg::CNT_W'(fkvc_pkg::DEPTH);
        else
            eff_cap = fkvc_pkg::CNT_W'(capacity_reg);
    end

    // A slot is live when its distance from the oldest slot is below the fill
    always_comb
    begin
        logic [fkvc_pkg::SLOT_W-1:0] ofs;
        for (int i = 0; i < fkvc_pkg::DEPTH; i++)
        begin
            ofs          = fkvc_pkg::SLOT_W'(i) - oldest_reg;
            match_vec[i] = (fkvc_pkg::CNT_W'(ofs) < fill_reg) && (key_store[i] == key_reg);
        end
    end

    // Live keys are unique, so any matching slot will do
    always_comb
    begin
        any_match  = |match_vec;
        first_slot = '0;
        for (int i = fkvc_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                first_slot = fkvc_pkg::SLOT_W'(i);
        end
    end

    // Evicting then appending lands on the same slot as a plain append
    assign append_slot = oldest_reg + fkvc_pkg::SLOT_W'(fill_reg);

    always_comb
    begin
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        hit_next    = 1'b0;
        vout_next   = '0;
        ev_next     = 1'b0;
        evkey_next  = '0;
        wr_key      = 1'b0;
        wr_val      = 1'b0;
        wr_slot     = append_slot;
        case (req_reg)
            fkvc_pkg::REQ_LOOKUP:
            begin
                hit_next = match_hit_reg;
                if (match_hit_reg)
                    vout_next = value_store[match_slot_reg];
            end
            fkvc_pkg::REQ_STORE:
            begin
                if (match_hit_reg)
                begin
                    hit_next = 1'b1;
                    wr_val   = 1'b1;
                    wr_slot  = match_slot_reg;
                end
                else
                begin
                    wr_key = 1'b1;
                    wr_val = 1'b1;
                    if (need_evict_reg)
                    begin
                        ev_next     = 1'b1;
                        evkey_next  = key_store[oldest_reg];
                        oldest_next = oldest_reg + fkvc_pkg::SLOT_W'(1);
                    end
                    else
                    begin
                        fill_next = fill_reg + fkvc_pkg::CNT_W'(1);
                    end
                end
            end
            fkvc_pkg::REQ_CLEAR:
            begin
                oldest_next = '0;
                fill_next   = '0;
            end
            default:
            begin
                // unused code: no change
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= fkvc_pkg::CAP_RESET;
            oldest_reg   <= '0;
            fill_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (cmd.commit)
            begin
                oldest_reg <= oldest_next;
                fill_reg   <= fill_next;
            end
            done_reg <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            key_reg <= key;
            val_reg <= value_in;
        end
        if (cmd.match)
        begin
            match_hit_reg  <= any_match;
            match_slot_reg <= first_slot;
            need_evict_reg <= (fill_reg >= eff_cap) && (fill_reg != '0);
        end
        if (cmd.commit)
        begin
            hit_reg   <= hit_next;
            vout_reg  <= vout_next;
            ev_reg    <= ev_next;
            evkey_reg <= evkey_next;
            if (wr_key)
                key_store[wr_slot] <= key_reg;
            if (wr_val)
                value_store[wr_slot] <= val_reg;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign value_out   = vout_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evkey_reg;
    assign entry_count = fill_reg;

endmodule

// ----- src/fifo_key_value_cache.sv -----
// Top level of the FIFO key-value cache: controller plus datapath.
// Depends on fkvc_pkg, fkvc_ctrl and fkvc_datapath.
`timescale 1ns / 1ps

// Channel   Ports                                          Handshake
// -------   ---------------------------------------------  ---------------------------
// request   req_type, key, value_in                        taken when start && !busy
// result    hit, value_out, evicted, evicted_key,          one cycle, marked by done
//           entry_count
// config    cfg_wdata (capacity)                           written when cfg_we
//
// Each item passes through three steps: accept/capture, a parallel compare of the key
// against all sixteen slots, then commit of the ring pointers and storage.
// The result strobe done rises in the cycle after commit, when busy has
// already dropped, so the next item may be started alongside it.
// Reset empties the ring and sets capacity to 16; slot contents are not
// cleared and are never read until written. The receiver cannot stall.

module fifo_key_value_cache
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [fkvc_pkg::REQ_W-1:0]      req_type,
    input  logic [fkvc_pkg::KEY_W-1:0]      key,
    input  logic [fkvc_pkg::VAL_W-1:0]      value_in,
    // result
    output logic                            done,
    output logic                            hit,
    output logic [fkvc_pkg::VAL_W-1:0]      value_out,
    output logic                            evicted,
    output logic [fkvc_pkg::KEY_W-1:0]      evicted_key,
    output logic [fkvc_pkg::CNT_W-1:0]      entry_count,
    // capacity register
    input  logic                            cfg_we,
    input  logic [fkvc_pkg::CAP_W-1:0]      cfg_wdata
);

    fkvc_pkg::cmd_t cmd;

    // Sequencer: IDLE -> MATCH -> COMMIT
    fkvc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Storage, compare, ring pointers and result registers
    fkvc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_type    (req_type),
        .key         (key),
        .value_in    (value_in),
        .done        (done),
        .hit         (hit),
        .value_out   (value_out),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .entry_count (entry_count)
    );

endmodule
